// ----- rtl/smt_pkg.sv -----
// smt_pkg: shared types and constants of the set membership test block
// used by smt_front, smt_back and set_membership_test_top; no dependencies
`default_nettype none

package smt_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int unsigned QIDX_W = 20;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ADD,
    CMD_QUERY
  } cmd_e;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } qhead_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DONE,
    ST_QCMP,
    ST_EMIT,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS
  } state_e;

  typedef struct packed {
    logic              in_set;
    logic [QIDX_W-1:0] query_index;
    logic              overflow;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/set_membership_test_top.sv -----
// Set membership test engine. A clear word is handled in the back end's idle state. A query
// word runs a binary search loop over the n stored elements, one compare per cycle against
// the registered read of the single-port store. An add word runs the same search, then moves
// each stored element above the insert point up one at a time through that port, with a read
// state and a write state per element; a final insert state writes the new element. A two-word
// command queue decouples input from the back end, and a result register decouples the back
// end from the output.
`default_nettype none

module set_membership_test_top #(
  parameter int unsigned SET_DEPTH   = 4096,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               in_set_o,
  output logic [smt_pkg::QIDX_W-1:0]         query_index_o,
  output logic                               overflow_o
);

  smt_pkg::qhead_t        head;
  logic [VALUE_WIDTH-1:0] head_key;
  logic                   pop;
  logic                   res_valid, res_ready;
  smt_pkg::result_t       res;
  logic                   out_valid_q;
  smt_pkg::result_t       out_q;

  smt_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .head_o     (head),
    .head_key_o (head_key),
    .pop_i      (pop)
  );

  smt_back #(
    .SET_DEPTH  (SET_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_key_i  (head_key),
    .pop_o       (pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output word register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign in_set_o      = out_q.in_set;
  assign query_index_o = out_q.query_index;
  assign overflow_o    = out_q.overflow;

endmodule

`default_nettype wire

// ----- rtl/smt_front.sv -----
// smt_front: accepts input words, decodes the opcode and queues commands
// depends on smt_pkg
`default_nettype none

module smt_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output smt_pkg::qhead_t                    head_o,
  output logic [VALUE_WIDTH-1:0]             head_key_o,
  input  wire logic                          pop_i
);

  logic [1:0]             cnt_q, cnt_d;
  logic                   wr_ptr_q, rd_ptr_q;
  smt_pkg::cmd_e          cmd_q [2];
  logic [VALUE_WIDTH-1:0] key_q [2];
  smt_pkg::cmd_e          in_cmd;
  logic                   in_known;
  logic                   push;
  logic [VALUE_WIDTH-1:0] in_key;

  // flip the sign bit so unsigned order matches signed order
  assign in_key = {~value_i[VALUE_WIDTH-1], value_i[VALUE_WIDTH-2:0]};

  always_comb begin
    in_known = 1'b1;
    in_cmd   = smt_pkg::CMD_CLEAR;
    case (opcode_i)
      smt_pkg::OP_CLEAR: in_cmd = smt_pkg::CMD_CLEAR;
      smt_pkg::OP_ADD:   in_cmd = smt_pkg::CMD_ADD;
      smt_pkg::OP_QUERY: in_cmd = smt_pkg::CMD_QUERY;
      default:           in_known = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && in_known;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= in_cmd;
      key_q[wr_ptr_q] <= in_key;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = cmd_q[rd_ptr_q];
  assign head_key_o   = key_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/smt_back.sv -----
// smt_back: sorted store, binary search and insertion sequencer
// depends on smt_pkg; fed by smt_front, drains into the output register
`default_nettype none

module smt_back #(
  parameter int unsigned SET_DEPTH   = 4096,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire smt_pkg::qhead_t        head_i,
  input  wire logic [VALUE_WIDTH-1:0] head_key_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  input  wire logic                   res_ready_i,
  output smt_pkg::result_t            res_o
);

  localparam int unsigned AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);
  localparam int unsigned QW = smt_pkg::QIDX_W;

  smt_pkg::state_e        state_q, state_d;
  logic [VALUE_WIDTH-1:0] mem [SET_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic [CW-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, j_q, j_d;
  logic [CW-1:0]          count_q, count_d;
  logic [QW-1:0]          qidx_q, qidx_d;
  logic                   ovf_q, ovf_d, found_q, found_d;
  smt_pkg::cmd_e          cmd_q, cmd_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;

  logic                   le;
  logic [CW-1:0]          lo_n, hi_n, mid_n, mid_start, j_m1;

  assign le        = (rdata_q <= key_q);
  assign lo_n      = le ? (mid_q + CW'(1)) : lo_q;
  assign hi_n      = le ? hi_q : mid_q;
  assign mid_n     = lo_n + ((hi_n - lo_n) >> 1);
  assign mid_start = count_q >> 1;
  assign j_m1      = j_q - CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smt_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.cmd)
            smt_pkg::CMD_ADD: begin
              if (count_q != DEPTH_C) begin
                state_d = (count_q != '0) ? smt_pkg::ST_CMP : smt_pkg::ST_DONE;
              end
            end
            smt_pkg::CMD_QUERY: begin
              state_d = (count_q != '0) ? smt_pkg::ST_CMP : smt_pkg::ST_DONE;
            end
            default: state_d = smt_pkg::ST_IDLE;
          endcase
        end
      end
      smt_pkg::ST_CMP: begin
        state_d = (lo_n < hi_n) ? smt_pkg::ST_CMP : smt_pkg::ST_DONE;
      end
      smt_pkg::ST_DONE: begin
        if (cmd_q == smt_pkg::CMD_ADD) begin
          state_d = (count_q == lo_q) ? smt_pkg::ST_INS : smt_pkg::ST_SH_RD;
        end else begin
          state_d = (lo_q == '0) ? smt_pkg::ST_EMIT : smt_pkg::ST_QCMP;
        end
      end
      smt_pkg::ST_QCMP:  state_d = smt_pkg::ST_EMIT;
      smt_pkg::ST_EMIT:  state_d = res_ready_i ? smt_pkg::ST_IDLE : smt_pkg::ST_EMIT;
      smt_pkg::ST_SH_RD: state_d = smt_pkg::ST_SH_WR;
      smt_pkg::ST_SH_WR: state_d = (j_m1 == lo_q) ? smt_pkg::ST_INS : smt_pkg::ST_SH_RD;
      smt_pkg::ST_INS:   state_d = smt_pkg::ST_IDLE;
      default:           state_d = smt_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop_o       = 1'b0;
    res_valid_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = mid_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = j_q[AW-1:0];
    wr_data     = rdata_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    j_d         = j_q;
    count_d     = count_q;
    qidx_d      = qidx_q;
    ovf_d       = ovf_q;
    found_d     = found_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    case (state_q)
      smt_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cmd_d = head_i.cmd;
          key_d = head_key_i;
          lo_d  = '0;
          hi_d  = count_q;
          mid_d = mid_start;
          case (head_i.cmd)
            smt_pkg::CMD_CLEAR: begin
              count_d = '0;
              qidx_d  = '0;
              ovf_d   = 1'b0;
            end
            smt_pkg::CMD_ADD: begin
              if (count_q == DEPTH_C) begin
                ovf_d = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = mid_start[AW-1:0];
              end
            end
            smt_pkg::CMD_QUERY: begin
              rd_en   = 1'b1;
              rd_addr = mid_start[AW-1:0];
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      smt_pkg::ST_CMP: begin
        lo_d    = lo_n;
        hi_d    = hi_n;
        mid_d   = mid_n;
        rd_en   = 1'b1;
        rd_addr = mid_n[AW-1:0];
      end
      smt_pkg::ST_DONE: begin
        j_d     = count_q;
        found_d = 1'b0;
        rd_en   = 1'b1;
        rd_addr = lo_q[AW-1:0] - AW'(1);
      end
      smt_pkg::ST_QCMP: begin
        found_d = (rdata_q == key_q);
      end
      smt_pkg::ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          qidx_d = qidx_q + QW'(1);
        end
      end
      smt_pkg::ST_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = j_m1[AW-1:0];
      end
      smt_pkg::ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = j_q[AW-1:0];
        wr_data = rdata_q;
        j_d     = j_m1;
      end
      smt_pkg::ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = lo_q[AW-1:0];
        wr_data = key_q;
        count_d = count_q + CW'(1);
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  assign res_o.in_set      = found_q;
  assign res_o.query_index = qidx_q;
  assign res_o.overflow    = ovf_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smt_pkg::ST_IDLE;
      count_q <= '0;
      qidx_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      qidx_q  <= qidx_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    j_q     <= j_d;
    found_q <= found_d;
    cmd_q   <= cmd_d;
    key_q   <= key_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("stored count beyond depth");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smt_pkg::ST_CMP |-> (lo_q <= mid_q) && (mid_q < hi_q))
    else $error("search probe outside window");

  a_shift_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smt_pkg::ST_SH_RD || state_q == smt_pkg::ST_SH_WR) |-> j_q > lo_q)
    else $error("shift index at or below insert position");

  a_qidx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smt_pkg::ST_EMIT && res_ready_i) |=> qidx_q == $past(qidx_q) + QW'(1))
    else $error("query index did not advance on result");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == smt_pkg::ST_IDLE && head_i.valid)
    else $error("queue popped while busy or empty");

endmodule

`default_nettype wire

// ----- tb/tb_set_membership_test_top.sv -----
// testbench for set_membership_test_top: directed, full-store and random add/query/clear words
// checked against a scoreboard class that keeps its own copy of the set
// depends on smt_pkg and the set_membership_test_top rtl
`default_nettype none

class membership_board;
  logic signed [31:0]           members[$];
  bit                           overflowed;
  logic [smt_pkg::QIDX_W-1:0]   next_index;
  smt_pkg::result_t             pending[$];
  int unsigned                  errors;
  int unsigned                  depth;

  function new(int unsigned set_depth);
    depth      = set_depth;
    overflowed = 1'b0;
    next_index = '0;
    errors     = 0;
  endfunction

  function void note_word(logic [1:0] op, logic signed [31:0] val);
    smt_pkg::result_t r;
    bit               hit;
    case (op)
      smt_pkg::OP_CLEAR: begin
        members.delete();
        overflowed = 1'b0;
        next_index = '0;
      end
      smt_pkg::OP_ADD: begin
        if (members.size() >= depth) overflowed = 1'b1;
        else members.push_back(val);
      end
      smt_pkg::OP_QUERY: begin
        hit = 1'b0;
        foreach (members[i]) if (members[i] == val) hit = 1'b1;
        r.in_set      = hit;
        r.query_index = next_index;
        r.overflow    = overflowed;
        pending.push_back(r);
        next_index = next_index + 1'b1;
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic in_set, logic [smt_pkg::QIDX_W-1:0] qidx, logic ovf);
    smt_pkg::result_t e;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result in_set=%0b query_index=%0d overflow=%0b",
               $time, in_set, qidx, ovf);
      return;
    end
    e = pending.pop_front();
    if (in_set !== e.in_set) begin
      errors++;
      $display("%0t: in_set mismatch, expected %0b actual %0b (query %0d)",
               $time, e.in_set, in_set, e.query_index);
    end
    if (qidx !== e.query_index) begin
      errors++;
      $display("%0t: query_index mismatch, expected %0d actual %0d",
               $time, e.query_index, qidx);
    end
    if (ovf !== e.overflow) begin
      errors++;
      $display("%0t: overflow mismatch, expected %0b actual %0b (query %0d)",
               $time, e.overflow, ovf, e.query_index);
    end
  endfunction
endclass

module tb_set_membership_test_top;

  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned VW          = 32;
  localparam int unsigned RAND_WORDS  = 1350;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   opcode_i    = smt_pkg::OP_CLEAR;
  logic signed [VW-1:0]         value_i     = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         in_set_o;
  logic [smt_pkg::QIDX_W-1:0]   query_index_o;
  logic                         overflow_o;

  membership_board board;
  bit              calm     = 1'b0;
  bit              hold_off = 1'b0;
  int unsigned     cycles   = 0;

  set_membership_test_top #(
    .SET_DEPTH  (DEPTH),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .in_set_o     (in_set_o),
    .query_index_o(query_index_o),
    .overflow_o   (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("set_membership_test_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_word(opcode_i, value_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(in_set_o, query_index_o, overflow_o);
  end

  // result side: random stall before each word unless calm, one long hold on request
  initial begin : receiver
    int unsigned n;
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        n = HOLD_CYCLES;
        hold_off = 1'b0;
      end else if (calm) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_word(input logic [1:0] op, input logic signed [31:0] val);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_until_empty();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
  endtask

  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 16)) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return V_MIN;
          1: return V_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 255)) - 128 + ($urandom_range(0, 1) ? V_MAX : V_MIN);
    endcase
  endfunction

  // mostly stored values and their neighbors, the rest anything
  function automatic logic signed [31:0] pick_query_value();
    logic signed [31:0] v;
    int unsigned        n;
    n = board.members.size();
    if (n == 0 || $urandom_range(0, 2) == 0) return draw_value();
    v = board.members[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 3))
      0: return v + 1;
      1: return v - 1;
      default: return v;
    endcase
  endfunction

  initial begin : stimulus
    longint             acc;
    int unsigned        words;
    int unsigned        rounds;
    int unsigned        nadd;
    int unsigned        nq;
    int unsigned        r;

    board = new(DEPTH);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty set, extremes, duplicates, unused opcode, clear
    send_word(smt_pkg::OP_QUERY, 32'sd0);
    send_word(smt_pkg::OP_QUERY, V_MIN);
    send_word(smt_pkg::OP_ADD, V_MAX);
    send_word(smt_pkg::OP_ADD, V_MIN);
    send_word(smt_pkg::OP_ADD, 32'sd0);
    send_word(smt_pkg::OP_ADD, -32'sd1);
    send_word(smt_pkg::OP_ADD, 32'sd0);
    send_word(OP_SPARE, 32'sd5);
    send_word(smt_pkg::OP_QUERY, V_MAX);
    send_word(smt_pkg::OP_QUERY, V_MIN);
    send_word(smt_pkg::OP_QUERY, 32'sd0);
    send_word(smt_pkg::OP_QUERY, -32'sd1);
    send_word(smt_pkg::OP_QUERY, 32'sd1);
    send_word(smt_pkg::OP_QUERY, V_MAX - 1);
    send_word(smt_pkg::OP_QUERY, V_MIN + 1);
    send_word(smt_pkg::OP_QUERY, 32'sd5);
    send_word(smt_pkg::OP_CLEAR, 32'sd0);
    send_word(smt_pkg::OP_QUERY, 32'sd0);
    pause_until_empty();

    // fill the store in ascending order, then push past capacity
    send_word(smt_pkg::OP_CLEAR, $urandom);
    acc = -64'sd2147483648 + $urandom_range(0, 1000);
    for (int i = 0; i < DEPTH; i++) begin
      acc = acc + $urandom_range(0, 1 << 19);
      send_word(smt_pkg::OP_ADD, (i == DEPTH - 1) ? V_MAX : acc[31:0]);
      if (i % 64 == 63) send_word(smt_pkg::OP_QUERY, pick_query_value());
    end
    send_word(smt_pkg::OP_QUERY, V_MAX);
    send_word(smt_pkg::OP_ADD, V_MIN);
    send_word(smt_pkg::OP_ADD, V_MAX);
    send_word(smt_pkg::OP_ADD, $urandom);
    send_word(smt_pkg::OP_QUERY, V_MIN);
    send_word(smt_pkg::OP_QUERY, V_MAX);

    // long hold on the result side while queries keep coming
    hold_off = 1'b1;
    repeat (30) send_word(smt_pkg::OP_QUERY, pick_query_value());
    pause_until_empty();
    send_word(smt_pkg::OP_CLEAR, 32'sd0);
    send_word(smt_pkg::OP_QUERY, V_MAX);

    // random rounds of load then query
    words  = 0;
    rounds = 0;
    while (words < RAND_WORDS) begin
      calm = ($urandom_range(0, 5) == 0);
      if (board.members.size() > 150 || $urandom_range(0, 3) == 0) begin
        send_word(smt_pkg::OP_CLEAR, $urandom);
        words++;
      end
      nadd = $urandom_range(0, 20);
      repeat (nadd) begin
        send_word(smt_pkg::OP_ADD, draw_value());
        words++;
      end
      nq = $urandom_range(1, 30);
      repeat (nq) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_word(OP_SPARE, $urandom);
        end else if (r == 1) begin
          send_word(smt_pkg::OP_ADD, draw_value());
          words++;
        end else if (r == 2) begin
          send_word(smt_pkg::OP_CLEAR, $urandom);
          words++;
        end else begin
          send_word(smt_pkg::OP_QUERY, pick_query_value());
          words++;
        end
      end
      rounds++;
      if (rounds % 10 == 0) pause_until_empty();
    end
    calm = 1'b0;
    send_word(smt_pkg::OP_QUERY, pick_query_value());
    pause_until_empty();
    repeat (100) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("set_membership_test_top verification clean");
    end else begin
      $display("set_membership_test_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
